### rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted table search
// Table geometry, operation codes, back end states and the command record
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned ValW       = 32;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  typedef enum logic {
    OpWrite  = 1'b0,
    OpSearch = 1'b1
  } op_e;

  typedef enum logic {
    StIdle,
    StProbe
  } state_e;

  // One classified command: for a write, data is the entry value; for a
  // search, data is the key.
  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] index;
    logic [ValW-1:0] data;
  } cmd_t;

endpackage

### rtl/core/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front: input stage
// Accepts input beats, classifies them as write or search and holds one
// command until the queue takes it.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic [IdxW-1:0]        entry_index_i,
  input  logic signed [ValW-1:0] entry_value_i,
  input  logic signed [ValW-1:0] search_key_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output cmd_t                   cmd_o
);

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d       = cmd_q;
    vld_d       = vld_q;
    cmd_d.op    = op_e'(op_i);
    cmd_d.index = entry_index_i;
    unique case (op_e'(op_i))
      OpWrite:  cmd_d.data = entry_value_i;
      OpSearch: cmd_d.data = search_key_i;
      default:  cmd_d.data = entry_value_i;
    endcase
    if (accept) begin
      vld_d = 1'b1;
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload holds unless a new beat lands.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

### rtl/core/sts_queue.sv
// ----------------------------------------------------------------------------
// sts_queue: command queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module sts_queue import sts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              slot_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCntW'(QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/core/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back: table and search engine
// Holds the table memory, executes writes and runs the half-interval search
// with one memory probe per cycle; drives the registered result.
// ----------------------------------------------------------------------------
module sts_back import sts_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] entries_in_use_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            found_o
);

  logic [ValW-1:0] table_mem [TableDepth];

  state_e          state_q, state_d;
  logic [CntW-1:0] low_q, low_d, high_q, high_d;
  logic [IdxW-1:0] mid_q, mid_d;
  logic [ValW-1:0] key_q, key_d;
  logic [ValW-1:0] rdata_q;
  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic [CntW-1:0] n_sat, new_low, new_high, span;
  logic            slot_free, hit, key_lt;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign n_sat       = (entries_in_use_i > CntW'(TableDepth)) ? CntW'(TableDepth)
                                                              : entries_in_use_i;
  assign hit         = rdata_q == key_q;
  assign key_lt      = $signed(key_q) < $signed(rdata_q);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    high_d      = high_q;
    mid_d       = mid_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = mid_q;
    new_low     = low_q;
    new_high    = high_q;
    span        = '0;

    unique case (state_q)
      StIdle: begin
        // Writes run at once; a search waits for a free result slot.
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OpWrite: begin
              cmd_ready_o = 1'b1;
              mem_we      = 1'b1;
            end
            OpSearch: begin
              if (slot_free) begin
                cmd_ready_o = 1'b1;
                key_d       = cmd_i.data;
                if (n_sat == '0) begin
                  out_valid_d = 1'b1;
                  found_d     = 1'b0;
                end else begin
                  low_d     = '0;
                  high_d    = n_sat;
                  span      = n_sat - 1'b1;
                  mid_d     = IdxW'(span >> 1);
                  mem_raddr = mid_d;
                  mem_re    = 1'b1;
                  state_d   = StProbe;
                end
              end
            end
            default: ;
          endcase
        end
      end
      StProbe: begin
        // Compare the probed entry, narrow the range, issue the next probe.
        if (hit) begin
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          state_d     = StIdle;
        end else begin
          if (key_lt) begin
            new_high = {1'b0, mid_q};
          end else begin
            new_low = {1'b0, mid_q} + 1'b1;
          end
          low_d  = new_low;
          high_d = new_high;
          if (new_low < new_high) begin
            span      = new_high - new_low - 1'b1;
            mid_d     = IdxW'(new_low + (span >> 1));
            mem_raddr = mid_d;
            mem_re    = 1'b1;
          end else begin
            out_valid_d = 1'b1;
            found_d     = 1'b0;
            state_d     = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    high_q  <= high_d;
    mid_q   <= mid_d;
    key_q   <= key_d;
    found_q <= found_d;
  end

  // Single-port table: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[cmd_i.index] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= table_mem[mem_raddr];
    end
  end

endmodule

### rtl/core/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search: membership search over a sorted table
// Top level: front end, command queue and table/search back end.
// ----------------------------------------------------------------------------
// The block holds a table of 1024 signed 32-bit entries that software loads
// in ascending order. A write beat (op 0) stores entry_value_i at
// entry_index_i and gives no result. A search beat (op 1) gives one result
// beat whose found_o flag tells whether search_key_i equals one of the first
// entries_in_use entries (values above 1024 act as 1024; 0 always gives not
// found). The search probes only entries the standard half-interval search
// visits, so only those need to have been written. Write entries_in_use
// through cfg_we_i/cfg_data_i only while the block is idle. Input beats
// pass a register stage and a two-entry queue before the back end, which
// owns the single-port table memory. A search makes at most
// ceil(log2(n + 1)) probes for n searched entries (11 for a full table),
// each probe being one read of that memory port. The result then sits in
// an output register, and the front end keeps taking beats meanwhile.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import sts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CntW-1:0]        cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic [IdxW-1:0]        entry_index_i,
  input  logic signed [ValW-1:0] entry_value_i,
  input  logic signed [ValW-1:0] search_key_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o
);

  logic [CntW-1:0] entries_in_use_q;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  // Hold the entry count; the user must change it only between beats, unchecked by the block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= '0;
    end else if (cfg_we_i) begin
      entries_in_use_q <= cfg_data_i;
    end
  end

  // Accept and classify input beats.
  sts_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .cmd_valid_o   (front_valid),
    .cmd_ready_i   (front_ready),
    .cmd_o         (front_cmd)
  );

  // Buffer commands so the front end keeps running during a search.
  sts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  // Execute writes and searches in order against the table.
  sts_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entries_in_use_i (entries_in_use_q),
    .cmd_valid_i      (back_valid),
    .cmd_ready_o      (back_ready),
    .cmd_i            (back_cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_table_binary_search
// Loads an ascending table prefix plus the entries on the topmost search
// path, then runs directed and random write/search beats over many table
// spans under changing back-pressure. Each search is predicted at acceptance
// and its found flag checked in order at the output.
// ----------------------------------------------------------------------------
module tb;
  import sts_pkg::*;

  localparam int unsigned SettleCycles = 40;   // covers writes still in the pipe
  localparam int unsigned HoldCycles   = 300;  // long receiver hold-off
  localparam int unsigned PhaseBeats   = 45;
  localparam int unsigned RandPhases   = 10;
  localparam int unsigned LoadSpan     = 256;  // leading entries loaded in order

  // One input beat as the driver presents it.
  typedef struct {
    op_e                    op;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] value;
    logic signed [ValW-1:0] key;
  } beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CntW-1:0]        cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   op_r = 1'b0;
  logic [IdxW-1:0]        idx_r = '0;
  logic signed [ValW-1:0] value_r = '0;
  logic signed [ValW-1:0] key_r = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   found;

  sorted_table_binary_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op_r),
    .entry_index_i (idx_r),
    .entry_value_i (value_r),
    .search_key_i  (key_r),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .found_o       (found)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Beats waiting to be driven, and found flags waiting to come out.
  beat_t beat_backlog[$];
  logic  found_q[$];

  // Table as the stimulus generator sees it (ahead of the block), and the
  // table and span as the block holds them at acceptance time.
  logic signed [ValW-1:0] plan_table   [TableDepth];
  bit                     plan_written [TableDepth];
  logic signed [ValW-1:0] shadow_table [TableDepth];
  logic [CntW-1:0]        span_cfg = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int err_cnt    = 0;
  int n_writes   = 0;
  int n_searches = 0;
  int n_hits     = 0;
  int n_spans    = 0;

  beat_t next_beat;
  logic  want_found;
  logic  exp_found;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Half-interval search over the leading entries: probe the lower middle,
  // stop on equality, otherwise keep the half that can still hold the key.
  function automatic logic search_span(input logic signed [ValW-1:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = (span_cfg > TableDepth) ? TableDepth : span_cfg;
    while (lo < hi) begin
      mid = lo + (hi - lo - 1) / 2;
      if (shadow_table[mid] == key) return 1'b1;
      if (key < shadow_table[mid]) hi = mid;
      else lo = mid + 1;
    end
    return 1'b0;
  endfunction

  // Walk the same probe sequence on the planned table and tell whether
  // every probed entry has been written.
  function automatic bit probes_written(input logic signed [ValW-1:0] key);
    int unsigned lo, hi, mid;
    if ($isunknown(key)) return 1'b0;
    lo = 0;
    hi = (span_cfg > TableDepth) ? TableDepth : span_cfg;
    while (lo < hi) begin
      mid = lo + (hi - lo - 1) / 2;
      if (!plan_written[mid]) return 1'b0;
      if (plan_table[mid] == key) return 1'b1;
      if (key < plan_table[mid]) hi = mid;
      else lo = mid + 1;
    end
    return 1'b1;
  endfunction

  // Pick a value that keeps the entry between its neighbors; if the
  // neighbors are already out of order, fall back to any value.
  function automatic logic signed [ValW-1:0] fitting_value(input int unsigned idx);
    longint lo, hi, span;
    longint unsigned r;
    if (idx == 0 || !plan_written[idx-1]) lo = -64'sd2147483648;
    else lo = longint'(plan_table[idx-1]);
    if (idx == TableDepth - 1 || !plan_written[idx+1]) hi = 64'sd2147483647;
    else hi = longint'(plan_table[idx+1]);
    if (lo > hi) return $urandom();
    span = hi - lo + 1;
    r = {$urandom(), $urandom()};
    return ValW'(lo + longint'(r % span));
  endfunction

  task automatic push_write(input int unsigned idx, input logic signed [ValW-1:0] val);
    beat_t b;
    b.op    = OpWrite;
    b.idx   = IdxW'(idx);
    b.value = val;
    b.key   = $urandom();  // unused by a write, keep it noisy
    plan_table[idx]   = val;
    plan_written[idx] = 1'b1;
    beat_backlog.push_back(b);
  endtask

  // Drop a search whose probe sequence would reach an unwritten entry.
  task automatic push_search(input logic signed [ValW-1:0] key);
    beat_t b;
    if (!probes_written(key)) return;
    b.op    = OpSearch;
    b.idx   = IdxW'($urandom());
    b.value = $urandom();
    b.key   = key;
    beat_backlog.push_back(b);
  endtask

  // Change the span only while the block is idle.
  task automatic write_span(input int unsigned n);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= CntW'(n);
    span_cfg = CntW'(n);
    n_spans++;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sample at the falling edge so every update of the rising edge is settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (beat_backlog.size() != 0 || in_valid || found_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 58; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 58; end
      default: begin send_idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  // Driver: predict each accepted beat, then offer the next one or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (op_r == OpWrite) begin
          shadow_table[idx_r] = value_r;
          n_writes++;
        end else begin
          want_found = search_span(key_r);
          found_q.push_back(want_found);
          n_searches++;
          n_hits += want_found;
        end
      end
      // Hold the current beat until taken; only then consider the next one.
      if (!in_valid || in_ready) begin
        if (beat_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = beat_backlog.pop_front();
          in_valid <= 1'b1;
          op_r     <= next_beat.op;
          idx_r    <= next_beat.idx;
          value_r  <= next_beat.value;
          key_r    <= next_beat.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, then
  // decide ready for the next cycle (long hold-off, random stall or ready).
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (found_q.size() == 0) begin
          report_mismatch($sformatf("result beat found=%0b with no search pending", found));
        end else begin
          exp_found = found_q.pop_front();
          if (found !== exp_found)
            report_mismatch($sformatf("found=%0b, expected %0b (span %0d)",
                                      found, exp_found, span_cfg));
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    longint                 acc;
    int unsigned            n, span, pos, r, lim, lo, hi, mid;
    logic signed [ValW-1:0] key;
    int unsigned            span_plan [RandPhases];
    bit                     on_spine [TableDepth];

    span_plan = '{3, 1024, 7, 2047, 200, 1025, 2, 1, 33, 0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table: every search misses, nothing is read.
    set_idling(0);
    write_span(0);
    push_search(0);
    push_search(-32'sd2147483648);
    push_search(32'sd2147483647);
    wait_drained();

    // Mark the entries that a search above every value visits in a full
    // table, so full-span searches at the extremes stay on written entries.
    lo = 0;
    hi = TableDepth;
    while (lo < hi) begin
      mid = lo + (hi - lo - 1) / 2;
      on_spine[mid] = 1'b1;
      lo = mid + 1;
    end

    // Load the leading entries and that path in ascending order, min at the
    // bottom and max at the top, with occasional duplicates. Sender gaps on
    // this pass.
    set_idling(1);
    acc = -64'sd2147483648;
    for (int i = 0; i < TableDepth; i++) begin
      if (i < LoadSpan || on_spine[i]) begin
        if (i == TableDepth - 1) acc = 64'sd2147483647;
        push_write(i, ValW'(acc));
        acc += $urandom_range(4000000, 0);
      end
    end
    wait_drained();

    // Directed searches at the span extremes.
    set_idling(0);
    write_span(1024);
    push_search(plan_table[0]);
    push_search(plan_table[TableDepth-1]);
    push_search(plan_table[511]);
    push_search(plan_table[200] + 1);
    push_search(0);
    wait_drained();
    write_span(2047);  // beyond depth: acts as a full table
    push_search(plan_table[TableDepth-1]);
    push_search(plan_table[1015]);
    wait_drained();
    write_span(1023);  // top entry drops out of reach
    push_search(plan_table[TableDepth-1]);
    push_search(plan_table[1022]);
    wait_drained();
    write_span(1);
    push_search(plan_table[0]);
    push_search(32'sd2147483647);
    wait_drained();
    write_span(2);
    push_search(plan_table[1]);
    push_search(plan_table[0] - 1);
    wait_drained();

    // Random phases: mostly searches with keys taken from or next to live
    // entries, plus writes that mostly keep the order and some that break it.
    for (int p = 0; p < RandPhases; p++) begin
      n = (span_plan[p] == 0) ? $urandom_range(1024, 1) : span_plan[p];
      span = (n > TableDepth) ? TableDepth : n;
      lim = (span > LoadSpan) ? LoadSpan : span;
      set_idling(p % 4);
      write_span(n);
      if (p == 4) hold_req++;  // receiver holds off while the sender keeps going
      for (int k = 0; k < PhaseBeats; k++) begin
        if (p == 6 && k == PhaseBeats / 2) wait_drained();  // sender pause
        r = $urandom_range(99);
        pos = $urandom_range(lim - 1);
        if (r < 65) begin
          r = $urandom_range(99);
          if (r < 55) key = plan_table[pos];
          else if (r < 80) key = plan_table[pos] + ($urandom_range(1) ? 1 : -1);
          else if (r < 88) begin
            case ($urandom_range(3))
              0: key = -32'sd2147483648;
              1: key = 32'sd2147483647;
              2: key = 0;
              default: key = -1;
            endcase
          end else key = $urandom();
          push_search(key);
        end else begin
          pos = ($urandom_range(3) == 0) ? $urandom_range(TableDepth - 1) : pos;
          if ($urandom_range(9) == 0) push_write(pos, $urandom());
          else push_write(pos, fitting_value(pos));
        end
      end
      wait_drained();
    end

    $display("Covered %0d table writes and %0d searches (%0d hits) over %0d span settings,",
             n_writes, n_searches, n_hits, n_spans);
    $display("from an empty table to a saturated span, with some entries left out of order.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Timeout with %0d results still outstanding", found_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
